>>> src/utf8sb_pkg.sv
`default_nettype none

package utf8sb_pkg;

  // Default number of slots in the code table.
  localparam int TableDepthDefault = 256;

  // Field widths fixed by the interface.
  localparam int CodeW    = 16;
  localparam int ByteW    = 8;
  localparam int EntryW   = CodeW + ByteW;
  localparam int CountW   = 9;
  localparam int StatusW  = 2;

  // Request opcodes.
  localparam logic OpLoad = 1'b0;
  localparam logic OpData = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StChar     = 2'd0;
  localparam logic [StatusW-1:0] StTooLarge = 2'd1;
  localparam logic [StatusW-1:0] StNoChar   = 2'd2;

  // Largest byte that passes through unchanged.
  localparam logic [ByteW-1:0] AsciiMax = 8'd127;

  // Number of continuation bytes announced by a lead byte.
  function automatic logic [2:0] trailing_count(input logic [ByteW-1:0] lead);
    logic [2:0] cnt;
    if (lead < 8'hC0) begin
      cnt = 3'd0;
    end else if (lead < 8'hE0) begin
      cnt = 3'd1;
    end else if (lead < 8'hF0) begin
      cnt = 3'd2;
    end else if (lead < 8'hF8) begin
      cnt = 3'd3;
    end else if (lead < 8'hFC) begin
      cnt = 3'd4;
    end else begin
      cnt = 3'd5;
    end
    return cnt;
  endfunction

  // Marker bits left in the sum of a sequence of the given trailing count.
  function automatic logic [31:0] seq_offset(input logic [2:0] len);
    logic [31:0] off;
    case (len)
      3'd1: off = 32'h0000_3080;
      3'd2: off = 32'h000E_2080;
      3'd3: off = 32'h03C8_2080;
      3'd4: off = 32'hFA08_2080;
      3'd5: off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

>>> src/utf8_to_single_byte_charset.sv
// Channel | Direction | Handshake              | Payload
// in      | request   | in_valid_i / in_stall_o | opcode, entry_index, entry_code,
//         |           |                         | entry_byte, data_byte, last
// out     | result    | out_valid_o / out_stall_i | out_byte, status, end_of_message
// cfg     | write     | cfg_valid_i / cfg_ready_o | entries_in_use
//
// A table load, a byte below 128, or a byte that does not complete a sequence is
// handled as it is accepted. A completed sequence is accepted, has its length offset
// subtracted in S_SUB, then runs a binary search in which each probe passes through
// S_PROBE and S_CMP with the registered table read (at most 9 probes for 256 entries);
// if the code is absent, S_PROBE finds the range empty; S_DONE hands over the result.
// The input stalls while a sequence is being resolved or while the output register
// holds a result that the receiver stalls. Reset clears the decoder state and the
// entry count; the table contents are undefined until loaded.
`default_nettype none

module utf8_to_single_byte_charset #(
  parameter int TableDepth = utf8sb_pkg::TableDepthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Request channel.
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            opcode_i,
  input  wire logic [7:0]                      entry_index_i,
  input  wire logic [utf8sb_pkg::CodeW-1:0]    entry_code_i,
  input  wire logic [utf8sb_pkg::ByteW-1:0]    entry_byte_i,
  input  wire logic [utf8sb_pkg::ByteW-1:0]    data_byte_i,
  input  wire logic                            last_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [utf8sb_pkg::ByteW-1:0]    out_byte_o,
  output logic      [utf8sb_pkg::StatusW-1:0]  status_o,
  output logic                                 end_of_message_o,
  // Configuration write channel.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [utf8sb_pkg::CountW-1:0]   entries_in_use_i
);

  import utf8sb_pkg::*;

  localparam int AW = $clog2(TableDepth);
  localparam int CW = $clog2(TableDepth + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUB   = 5'b00010,
    S_PROBE = 5'b00100,
    S_CMP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [31:0]         acc_q, acc_d;
  logic [2:0]          rem_q, rem_d;
  logic [2:0]          len_q, len_d;
  logic                skip_q, skip_d;
  logic                last_q, last_d;
  logic [CodeW-1:0]    key_q, key_d;
  logic [CW-1:0]       lo_q, lo_d;
  logic [CW-1:0]       hi_q, hi_d;
  logic [CW-1:0]       mid_q, mid_d;
  logic [ByteW-1:0]    res_byte_q, res_byte_d;
  logic [StatusW-1:0]  res_status_q, res_status_d;
  logic [CountW-1:0]   entries_q;

  logic                out_valid_q;
  logic [ByteW-1:0]    out_byte_q;
  logic [StatusW-1:0]  out_status_q;
  logic                out_eom_q;

  logic                in_accept;
  logic                out_free;
  logic                load;
  logic                clear;
  logic [ByteW-1:0]    ld_byte;
  logic [StatusW-1:0]  ld_status;
  logic                ld_eom;
  logic [2:0]          lead_cnt;
  logic [31:0]         value_w;
  logic [31:0]         limit_w;
  logic [CW-1:0]       mid_w;
  logic                probe_go;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EntryW-1:0]   ram_wdata;
  logic [EntryW-1:0]   ram_rdata;
  logic [CodeW-1:0]    rd_key;
  logic [ByteW-1:0]    rd_byte;

  // Handshakes: the output register is free if empty or being drained this cycle.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == S_IDLE) && out_free);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Entry count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entries_q <= entries_in_use_i;
    end
  end

  // Search limit: counts beyond the table size mean the whole table.
  assign limit_w = ({23'd0, entries_q} > 32'(TableDepth)) ? 32'(TableDepth)
                                                         : {23'd0, entries_q};

  // Table storage: code in the upper bits, code page byte in the lower bits.
  assign ram_we    = in_accept && (opcode_i == OpLoad)
                     && ({24'd0, entry_index_i} < 32'(TableDepth));
  assign ram_waddr = AW'(entry_index_i);
  assign ram_wdata = {entry_code_i, entry_byte_i};
  assign rd_key    = ram_rdata[EntryW-1:ByteW];
  assign rd_byte   = ram_rdata[ByteW-1:0];

  assign mid_w    = lo_q + ((hi_q - lo_q) >> 1);
  assign probe_go = (state_q == S_PROBE) && (lo_q < hi_q);

  utf8sb_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (probe_go),
    .raddr_i (mid_w[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign lead_cnt = trailing_count(data_byte_i);
  assign value_w  = acc_q - seq_offset(len_q);

  // Sequencer: decode bytes, then resolve a code by repeated probes of the table.
  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    len_d        = len_q;
    skip_d       = skip_q;
    last_d       = last_q;
    key_d        = key_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_byte_d   = res_byte_q;
    res_status_d = res_status_q;
    load         = 1'b0;
    clear        = 1'b0;
    ld_byte      = '0;
    ld_status    = StChar;
    ld_eom       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept && (opcode_i == OpData)) begin
          last_d = last_i;
          if (skip_q) begin
            // The rest of a message after an error is dropped.
            if (last_i) begin
              load      = 1'b1;
              ld_status = StNoChar;
              ld_eom    = 1'b1;
              clear     = 1'b1;
            end
          end else if (rem_q == 3'd0) begin
            if (data_byte_i <= AsciiMax) begin
              load    = 1'b1;
              ld_byte = data_byte_i;
              ld_eom  = last_i;
              clear   = last_i;
            end else begin
              acc_d = {24'd0, data_byte_i};
              len_d = lead_cnt;
              rem_d = lead_cnt;
              if (lead_cnt != 3'd0) begin
                if (last_i) begin
                  load      = 1'b1;
                  ld_status = StNoChar;
                  ld_eom    = 1'b1;
                  clear     = 1'b1;
                end
              end else begin
                state_d = S_SUB;
              end
            end
          end else begin
            acc_d = {acc_q[25:0], 6'd0} + {24'd0, data_byte_i};
            rem_d = rem_q - 3'd1;
            if (rem_q != 3'd1) begin
              if (last_i) begin
                load      = 1'b1;
                ld_status = StNoChar;
                ld_eom    = 1'b1;
                clear     = 1'b1;
              end
            end else begin
              state_d = S_SUB;
            end
          end
        end
      end

      S_SUB: begin
        // Remove the marker bits and check the code range.
        acc_d = '0;
        len_d = '0;
        if (value_w[31:16] != 16'd0) begin
          skip_d       = 1'b1;
          res_byte_d   = '0;
          res_status_d = StTooLarge;
          state_d      = S_DONE;
        end else begin
          key_d   = value_w[CodeW-1:0];
          lo_d    = '0;
          hi_d    = CW'(limit_w);
          state_d = S_PROBE;
        end
      end

      S_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_w;
          state_d = S_CMP;
        end else begin
          res_byte_d   = '0;
          res_status_d = StChar;
          state_d      = S_DONE;
        end
      end

      S_CMP: begin
        if (key_q > rd_key) begin
          lo_d    = mid_q + CW'(1);
          state_d = S_PROBE;
        end else if (key_q < rd_key) begin
          hi_d    = mid_q;
          state_d = S_PROBE;
        end else begin
          res_byte_d   = rd_byte;
          res_status_d = StChar;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          load      = 1'b1;
          ld_byte   = res_byte_q;
          ld_status = res_status_q;
          ld_eom    = last_q;
          clear     = last_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The end of a message resets the decoder.
    if (clear) begin
      acc_d  = '0;
      rem_d  = '0;
      len_d  = '0;
      skip_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      rem_q   <= '0;
      len_q   <= '0;
      skip_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      last_q  <= last_d;
    end
  end

  // Search and result payload.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    res_byte_q   <= res_byte_d;
    res_status_q <= res_status_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_status_q <= StChar;
      out_eom_q    <= 1'b0;
    end else if (load) begin
      out_valid_q  <= 1'b1;
      out_byte_q   <= ld_byte;
      out_status_q <= ld_status;
      out_eom_q    <= ld_eom;
    end else if (!out_stall_i) begin
      out_valid_q  <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign status_o         = out_status_q;
  assign end_of_message_o = out_eom_q;

endmodule

`default_nettype wire

>>> src/utf8sb_ram.sv
`default_nettype none

module utf8sb_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/utf8sb_checker.sv
`default_nettype none

module utf8sb_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [utf8sb_pkg::ByteW-1:0]    out_byte_o,
  input wire logic [utf8sb_pkg::StatusW-1:0]  status_o,
  input wire logic                            end_of_message_o
);

  import utf8sb_pkg::*;

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StChar || status_o == StTooLarge || status_o == StNoChar))
    else $error("undefined status code on result");

  // Error and end-only results carry a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StChar) |-> (out_byte_o == '0))
    else $error("nonzero byte on a result without a character");

  // A result without a character is only given at the end of a message.
  a_nochar_eom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StNoChar) |-> end_of_message_o)
    else $error("status without character outside end of message");

  // A stalled result blocks new requests.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("request taken while a result is stalled");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_byte_o)
                                      && $stable(status_o) && $stable(end_of_message_o)))
    else $error("stalled result changed");

endmodule

bind utf8_to_single_byte_charset utf8sb_checker u_utf8sb_checker (.*);

`default_nettype wire
